// ===== design/mixing_buffer_window_search_assert.svh =====
`ifndef MIXING_BUFFER_WINDOW_SEARCH_ASSERT_SVH
`define MIXING_BUFFER_WINDOW_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MBWS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MBWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mbws_pkg.sv =====
package mbws_pkg;

	localparam int DEPTH = 32;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CUR_W = $clog2(DEPTH + 1);
	localparam int SUM_W = SLOT_W + 1;
	localparam logic [CUR_W-1:0] FILL_FULL = CUR_W'(DEPTH);
	localparam logic [SLOT_W-1:0] HEAD_LAST = SLOT_W'(DEPTH - 1);
	localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

	localparam int TAG_W = 16;
	localparam int MULT_W = 12;
	localparam int MATCH_SLOT_W = 5;
	localparam int MIX_W = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 12;

	localparam logic [MULT_W-1:0] DELTA_MAX_RST = MULT_W'(100);
	localparam logic [MIX_W-1:0] MAX_MIXED_RST = MIX_W'(2);

	typedef enum logic [0:0] {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_EVICTED = 3'd1,
		ST_MATCH   = 3'd2,
		ST_NONE    = 3'd3,
		ST_LIMIT   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELTA_MAX = 4'd0,
		CFG_MAX_MIXED = 4'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [TAG_W-1:0]  event_tag;
		logic [MULT_W-1:0] multiplicity;
		logic              restart;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [TAG_W-1:0]        match_tag;
		logic [MATCH_SLOT_W-1:0] match_slot;
		logic [MULT_W-1:0]       match_multiplicity;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [MULT_W-1:0] mult;
	} entry_t;

	typedef struct packed {
		logic item_load;
		logic do_add;
		logic set_limit;
		logic start_query;
		logic rd_en;
		logic set_none;
		logic set_found;
		logic advance;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_add;
		logic limit_hit;
		logic scan_end;
		logic hit;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== design/mbws_ram.sv =====
module mbws_ram #(
	parameter int Width = 8,
	parameter int Depth = 32,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mbws_ctrl.sv =====
module mbws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  mbws_pkg::ctl_sts_t sts,
	output mbws_pkg::ctl_cmd_t cmd
);

	mbws_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbws_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			mbws_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.item_load = 1'b1;
					state_d = mbws_pkg::S_EXEC;
				end
			end
			mbws_pkg::S_EXEC: begin
				if (sts.is_add) begin
					cmd.do_add = 1'b1;
					state_d = mbws_pkg::S_FINISH;
				end else if (sts.limit_hit) begin
					cmd.set_limit = 1'b1;
					state_d = mbws_pkg::S_FINISH;
				end else begin
					cmd.start_query = 1'b1;
					state_d = mbws_pkg::S_READ;
				end
			end
			mbws_pkg::S_READ: begin
				if (sts.scan_end) begin
					cmd.set_none = 1'b1;
					state_d = mbws_pkg::S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = mbws_pkg::S_CHECK;
				end
			end
			mbws_pkg::S_CHECK: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d = mbws_pkg::S_FINISH;
				end else begin
					cmd.advance = 1'b1;
					state_d = mbws_pkg::S_READ;
				end
			end
			mbws_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = mbws_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mbws_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/mbws_datapath.sv =====
`include "mixing_buffer_window_search_assert.svh"

module mbws_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbws_pkg::req_t                      req,
	input  mbws_pkg::ctl_cmd_t                  cmd,
	output mbws_pkg::ctl_sts_t                  sts,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output mbws_pkg::rsp_t                      rsp
);

	mbws_pkg::req_t                    item_q;
	mbws_pkg::rsp_t                    res_q;
	mbws_pkg::rsp_t                    out_q;
	logic                              out_valid_q;
	logic [mbws_pkg::CUR_W-1:0]        fill_q;
	logic [mbws_pkg::CUR_W-1:0]        cursor_q;
	logic [mbws_pkg::SLOT_W-1:0]       head_q;
	logic [mbws_pkg::MIX_W-1:0]        mixed_q;
	logic [mbws_pkg::MULT_W-1:0]       delta_q;
	logic [mbws_pkg::MIX_W-1:0]        max_mixed_q;

	logic [mbws_pkg::CUR_W-1:0]        cur_eff;
	logic [mbws_pkg::MIX_W-1:0]        mix_eff;
	logic [mbws_pkg::SLOT_W-1:0]       head_new;
	logic [mbws_pkg::SUM_W-1:0]        addr_sum;
	logic [mbws_pkg::SUM_W-1:0]        addr_wrap;
	logic [mbws_pkg::SLOT_W-1:0]       raddr;
	logic                              full;
	mbws_pkg::entry_t                  wentry;
	mbws_pkg::entry_t                  rentry;
	logic [mbws_pkg::MULT_W-1:0]       diff;

	assign cfg_ready = 1'b1;

	assign cur_eff = item_q.restart ? '0 : cursor_q;
	assign mix_eff = item_q.restart ? '0 : mixed_q;
	assign full = (fill_q == mbws_pkg::FILL_FULL);
	assign head_new = (head_q == '0) ? mbws_pkg::HEAD_LAST : head_q - 1'b1;

	// map logical slot to physical address of the ring
	assign addr_sum = mbws_pkg::SUM_W'(head_q) + mbws_pkg::SUM_W'(cursor_q);
	assign addr_wrap = (addr_sum >= mbws_pkg::SUM_WRAP) ? addr_sum - mbws_pkg::SUM_WRAP
		: addr_sum;
	assign raddr = addr_wrap[mbws_pkg::SLOT_W-1:0];

	assign wentry.tag = item_q.event_tag;
	assign wentry.mult = item_q.multiplicity;

	mbws_ram #(
		.Width($bits(mbws_pkg::entry_t)),
		.Depth(mbws_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.do_add),
		.waddr(head_new),
		.wdata(wentry),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rentry)
	);

	assign diff = (rentry.mult > item_q.multiplicity) ? rentry.mult - item_q.multiplicity
		: item_q.multiplicity - rentry.mult;

	assign sts.is_add = (item_q.cmd == mbws_pkg::CMD_ADD);
	assign sts.limit_hit = (mix_eff >= max_mixed_q);
	assign sts.scan_end = (cursor_q >= fill_q);
	assign sts.hit = (diff <= delta_q);
	assign sts.out_free = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= req;
		end
		if (cmd.do_add) begin
			res_q <= '{status: full ? mbws_pkg::ST_EVICTED : mbws_pkg::ST_ADDED,
				default: '0};
		end else if (cmd.set_limit) begin
			res_q <= '{status: mbws_pkg::ST_LIMIT, default: '0};
		end else if (cmd.set_none) begin
			res_q <= '{status: mbws_pkg::ST_NONE, default: '0};
		end else if (cmd.set_found) begin
			res_q.status <= mbws_pkg::ST_MATCH;
			res_q.match_tag <= rentry.tag;
			res_q.match_slot <= mbws_pkg::MATCH_SLOT_W'(cursor_q);
			res_q.match_multiplicity <= rentry.mult;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
			cursor_q <= '0;
			mixed_q <= '0;
			delta_q <= mbws_pkg::DELTA_MAX_RST;
			max_mixed_q <= mbws_pkg::MAX_MIXED_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					mbws_pkg::CFG_DELTA_MAX: delta_q <= cfg_data;
					mbws_pkg::CFG_MAX_MIXED: max_mixed_q <= cfg_data[mbws_pkg::MIX_W-1:0];
					default: ;
				endcase
			end
			if (cmd.do_add) begin
				head_q <= head_new;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.set_limit) begin
				cursor_q <= cur_eff;
				mixed_q <= mix_eff;
			end
			if (cmd.start_query) begin
				cursor_q <= (cur_eff == mbws_pkg::FILL_FULL) ? cur_eff : cur_eff + 1'b1;
				mixed_q <= mix_eff + 1'b1;
			end
			if (cmd.advance) begin
				cursor_q <= cursor_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MBWS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= mbws_pkg::FILL_FULL, "fill past depth")
	`MBWS_ASSERT_IMPL(a_cursor_bound, 1'b1, cursor_q <= mbws_pkg::FILL_FULL, "cursor past depth")
	`MBWS_ASSERT_IMPL(a_read_in_fill, cmd.rd_en, cursor_q < fill_q, "read beyond fill")
	`MBWS_ASSERT_NEXT(a_evict_flag, cmd.do_add && full, res_q.status == mbws_pkg::ST_EVICTED,
		"eviction not flagged")

endmodule

// ===== design/mixing_buffer_window_search.sv =====
// Mixing buffer with a multiplicity-window search.
// Request channel (req_valid, req_stall, req): cmd 0 adds a record at slot 0
// and pushes older records down; cmd 1 queries for the next record whose
// multiplicity lies within delta_max of the query's, starting one past the
// cursor. Every request yields exactly one response beat on rsp_valid,
// rsp_stall, rsp. Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes delta_max (index 0) and max_mixed (index 1); write only while idle.
// Records sit in a ring in a single RAM; one beat is accepted at a time.
// An add, or a query stopped by the limit, passes from EXEC straight to
// FINISH. A query alternates READ, which reads one slot from the RAM, and
// CHECK, which compares it, until a slot matches or the scan runs off the
// fill. At most 31 slots are examined.
// The next request is accepted the cycle after the response is loaded.
// Reset empties the buffer, zeroes cursor and mixed count and restores
// delta_max 100 and max_mixed 2; no clearing pass is needed.
// A stalled response holds; the block still accepts a new request and
// finishes it, then waits with the new result until the output frees up.
module mixing_buffer_window_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  mbws_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output mbws_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mbws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbws_pkg::CFG_DATA_W-1:0] cfg_data
);

	mbws_pkg::ctl_cmd_t cmd;
	mbws_pkg::ctl_sts_t sts;

	mbws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbws_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== dv/mixing_buffer_window_search_tb.sv =====
`timescale 1ns / 100ps

module mixing_buffer_window_search_tb;
	import mbws_pkg::*;

	class mixing_scoreboard;
		entry_t            records [DEPTH];
		logic [CUR_W-1:0]  fill_cnt;
		logic [CUR_W-1:0]  cursor;
		logic [MIX_W-1:0]  mixed_cnt;
		logic [MULT_W-1:0] delta_max;
		logic [MIX_W-1:0]  max_mixed;
		rsp_t              awaiting [$];
		int                mismatches;
		int                requests;
		int                by_status [8];

		function new();
			fill_cnt = '0;
			cursor = '0;
			mixed_cnt = '0;
			delta_max = DELTA_MAX_RST;
			max_mixed = MAX_MIXED_RST;
			mismatches = 0;
			requests = 0;
			foreach (by_status[i])
				by_status[i] = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_DELTA_MAX)
				delta_max = data[MULT_W-1:0];
			else if (idx == CFG_MAX_MIXED)
				max_mixed = data[MIX_W-1:0];
		endfunction

		function rsp_t search_step(req_t r);
			rsp_t              o;
			logic [MULT_W-1:0] m;
			logic [MULT_W-1:0] d;
			o = '0;
			if (r.cmd == CMD_ADD) begin
				if (fill_cnt == FILL_FULL) begin
					o.status = ST_EVICTED;
				end else begin
					fill_cnt++;
					o.status = ST_ADDED;
				end
				for (int i = DEPTH - 1; i > 0; i--)
					records[i] = records[i-1];
				records[0].tag = r.event_tag;
				records[0].mult = r.multiplicity;
				return o;
			end
			if (r.restart) begin
				cursor = '0;
				mixed_cnt = '0;
			end
			if (mixed_cnt >= max_mixed) begin
				o.status = ST_LIMIT;
				return o;
			end
			if (cursor < FILL_FULL)
				cursor++;
			while (cursor < fill_cnt) begin
				m = records[cursor].mult;
				d = (m > r.multiplicity) ? m - r.multiplicity : r.multiplicity - m;
				if (d <= delta_max)
					break;
				cursor++;
			end
			mixed_cnt++;
			if (cursor < fill_cnt) begin
				o.status = ST_MATCH;
				o.match_tag = records[cursor].tag;
				o.match_slot = cursor[MATCH_SLOT_W-1:0];
				o.match_multiplicity = records[cursor].mult;
			end else begin
				o.status = ST_NONE;
			end
			return o;
		endfunction

		function void note_request(req_t r);
			requests++;
			awaiting.push_back(search_step(r));
		endfunction

		task report(string what, int exp_val, int got_val);
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_val,
				got_val);
			mismatches++;
		endtask

		task check_response(rsp_t got);
			rsp_t exp_rsp;
			if (awaiting.size() == 0) begin
				report("unexpected response beat, status", -1, got.status);
				return;
			end
			exp_rsp = awaiting.pop_front();
			by_status[got.status]++;
			if (got.status !== exp_rsp.status)
				report("status", exp_rsp.status, got.status);
			if (got.match_tag !== exp_rsp.match_tag)
				report("match_tag", exp_rsp.match_tag, got.match_tag);
			if (got.match_slot !== exp_rsp.match_slot)
				report("match_slot", exp_rsp.match_slot, got.match_slot);
			if (got.match_multiplicity !== exp_rsp.match_multiplicity)
				report("match_multiplicity", exp_rsp.match_multiplicity,
					got.match_multiplicity);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mixing_scoreboard sb = new();
	bit               calm = 1'b0;
	int               mult_center;
	int               mult_spread;
	int               settings_run = 0;

	mixing_buffer_window_search i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic req_t make_req(cmd_t c, logic [TAG_W-1:0] t, logic [MULT_W-1:0] m,
			logic rs);
		req_t x;
		x.cmd = c;
		x.event_tag = t;
		x.multiplicity = m;
		x.restart = rs;
		return x;
	endfunction

	function automatic logic [MULT_W-1:0] pick_mult(bit near);
		int v;
		if (!near)
			return MULT_W'($urandom_range(0, 4095));
		v = mult_center + $urandom_range(0, 2 * mult_spread) - mult_spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return MULT_W'(v);
	endfunction

	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 2) != 0) begin
				rsp_stall = 1'b0;
			end else begin
				rsp_stall = 1'b1;
				repeat (idle_len()) @(negedge clk);
				rsp_stall = 1'b0;
			end
		end
	end

	initial begin
		forever begin
			repeat ($urandom_range(200, 2000)) @(negedge clk);
			calm = ~calm;
		end
	end

	initial begin
		#15ms;
		$display("Some tests failed");
		$finish;
	end

	task automatic send(req_t item);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = item;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(item);
		@(negedge clk);
	endtask

	// hold off until every pending response has come back
	task automatic drain();
		req_valid = 1'b0;
		while (sb.awaiting.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_window(int dm, int mm);
		write_reg(CFG_DELTA_MAX, CFG_DATA_W'(dm));
		write_reg(CFG_MAX_MIXED, {4'($urandom), 8'(mm)});
		mult_center = $urandom_range(0, 4095);
		mult_spread = (dm / 2 + 4 > 300) ? 300 : dm / 2 + 4;
		settings_run++;
	endtask

	task automatic run_directed();
		send(make_req(CMD_QUERY, 16'hFFFF, 12'h000, 1'b1));
		send(make_req(CMD_QUERY, 16'h0000, 12'hFFF, 1'b0));
		send(make_req(CMD_QUERY, 16'h0000, 12'hFFF, 1'b0));
		send(make_req(CMD_ADD, 16'h0000, 12'h000, 1'b1));
		send(make_req(CMD_ADD, 16'hFFFF, 12'hFFF, 1'b0));
		send(make_req(CMD_ADD, 16'h1234, 12'd100, 1'b0));
		send(make_req(CMD_ADD, 16'h8001, 12'd200, 1'b1));
		send(make_req(CMD_QUERY, 16'hA5A5, 12'h000, 1'b1));
		send(make_req(CMD_QUERY, 16'h0000, 12'h000, 1'b0));
		send(make_req(CMD_QUERY, 16'h0000, 12'h000, 1'b0));
		send(make_req(CMD_QUERY, 16'h0000, 12'hFFF, 1'b1));
		// add mid-search: cursor now points one record further back
		send(make_req(CMD_ADD, 16'h5555, 12'hFFF, 1'b0));
		send(make_req(CMD_QUERY, 16'h0000, 12'hFFF, 1'b0));
		send(make_req(CMD_QUERY, 16'h7FFF, 12'd2048, 1'b1));
	endtask

	task automatic run_random(int n);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				len = $urandom_range(1, 40);
				for (int k = 0; k < len; k++)
					send(make_req(CMD_ADD, TAG_W'($urandom), pick_mult($urandom_range(0, 3) != 0),
						1'($urandom)));
			end else if (r < 88) begin
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++)
					send(make_req(CMD_QUERY, TAG_W'($urandom),
						pick_mult($urandom_range(0, 4) != 0), k == 0));
			end else begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send(make_req(cmd_t'($urandom_range(0, 1)), TAG_W'($urandom),
						MULT_W'($urandom), 1'($urandom)));
			end
			sent += len;
			if ($urandom_range(0, 19) == 0)
				drain();
		end
	endtask

	initial begin
		int dm_list [10] = '{0, 4095, 50, 0, 200, 4095, 10, 100, 0, 0};
		int mm_list [10] = '{255, 255, 20, 0, 8, 1, 255, 2, 0, 0};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		drain();

		dm_list[8] = $urandom_range(0, 4095);
		mm_list[8] = $urandom_range(0, 255);
		dm_list[9] = $urandom_range(0, 600);
		mm_list[9] = $urandom_range(1, 40);
		for (int p = 0; p < 10; p++) begin
			set_window(dm_list[p], mm_list[p]);
			run_random(145);
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d requests over %0d register settings plus reset defaults.",
			sb.requests, settings_run);
		$display("Responses: %0d added, %0d evicted, %0d matched, %0d none, %0d at limit.",
			sb.by_status[ST_ADDED], sb.by_status[ST_EVICTED], sb.by_status[ST_MATCH],
			sb.by_status[ST_NONE], sb.by_status[ST_LIMIT]);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/mbws_pkg.sv
design/mbws_ram.sv
design/mbws_ctrl.sv
design/mbws_datapath.sv
design/mixing_buffer_window_search.sv
dv/mixing_buffer_window_search_tb.sv
